// File: rtl/suvm_pkg.sv
// Package for the spherical UV mapping core: angle table and shared constants.
// Used by spherical_uv_mapping_core and suvm_cordic_pipe; no dependencies.
package suvm_pkg;

  localparam int unsigned AngW = 34;       // angle accumulator width, units of 2^-32 turn
  localparam int unsigned AtanEntries = 32;

  localparam logic signed [AngW-1:0] HalfTurn    = 34'sd2147483648;
  localparam logic signed [AngW-1:0] QuarterTurn = 34'sd1073741824;

  // Flags that travel with one vertex through the pipeline.
  typedef struct packed {
    logic y_clamped;
  } suvm_side_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
      5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
      5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
      5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001; default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // Angle in units of 2^-32 turn to Q0.16, rounded half up, saturated.
  function automatic logic [15:0] to_q16(input logic signed [AngW+1:0] a);
    logic signed [AngW+1:0] r;
    r = (a + 36'sd32768) >>> 16;
    if (a < 0) return 16'd0;
    if (r > 36'sd65535) return 16'hFFFF;
    return r[15:0];
  endfunction

endpackage

// File: rtl/suvm_cordic_pipe.sv
// Pipelined vectoring CORDIC: atan2(b, a) in units of 2^-32 turn, one stage per rotation.
// Depends on suvm_pkg; carries an opaque tag alongside each request.
module suvm_cordic_pipe #(
  parameter int unsigned InW    = 17,
  parameter int unsigned Stages = 16,
  parameter int unsigned Shift  = 30,
  parameter int unsigned TagW   = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [InW-1:0]            a_i,
  input  logic signed [InW-1:0]            b_i,
  input  logic [TagW-1:0]                  tag_i,
  output logic                             valid_o,
  output logic signed [suvm_pkg::AngW-1:0] ang_o,
  output logic [TagW-1:0]                  tag_o
);
  import suvm_pkg::*;

  localparam int unsigned Run = (Stages < 32) ? Stages : 32;
  localparam int unsigned WW  = InW + Shift + 3;

  logic                   vld_q [Run+1];
  logic signed [WW-1:0]   a_q   [Run+1];
  logic signed [WW-1:0]   b_q   [Run+1];
  logic signed [AngW-1:0] acc_q [Run+1];
  logic [TagW-1:0]        tag_q [Run+1];

  // Entry stage: axis shortcuts and half-plane fold.
  logic signed [WW-1:0]   a0_d, b0_d;
  logic signed [AngW-1:0] acc0_d;
  logic                   done_d;
  logic                   done_q [Run+1];
  always_comb begin
    a0_d = WW'(a_i) <<< Shift;
    b0_d = WW'(b_i) <<< Shift;
    acc0_d = '0;
    done_d = 1'b0;
    if (b_i == 0) begin
      acc0_d = (a_i < 0) ? HalfTurn : '0;
      done_d = 1'b1;
    end else if (a_i == 0) begin
      acc0_d = (b_i > 0) ? QuarterTurn : -QuarterTurn;
      done_d = 1'b1;
    end else if (a_i < 0) begin
      acc0_d = (b_i > 0) ? HalfTurn : -HalfTurn;
      a0_d = -a0_d;
      b0_d = -b0_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q[0] <= a0_d; b_q[0] <= b0_d; acc_q[0] <= acc0_d;
      done_q[0] <= done_d; tag_q[0] <= tag_i;
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < Run; i++) begin : g_stage
    logic signed [WW-1:0]   da, db;
    logic signed [AngW-1:0] at;
    assign da = b_q[i] >>> i;
    assign db = a_q[i] >>> i;
    assign at = AngW'(atan_turn(5'(i)));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[i+1]  <= tag_q[i];
        done_q[i+1] <= done_q[i];
        if (done_q[i]) begin
          a_q[i+1] <= a_q[i]; b_q[i+1] <= b_q[i]; acc_q[i+1] <= acc_q[i];
        end else if (b_q[i] >= 0) begin
          a_q[i+1] <= a_q[i] + da; b_q[i+1] <= b_q[i] - db; acc_q[i+1] <= acc_q[i] + at;
        end else begin
          a_q[i+1] <= a_q[i] - da; b_q[i+1] <= b_q[i] + db; acc_q[i+1] <= acc_q[i] - at;
        end
      end
    end
  end

  assign valid_o = vld_q[Run];
  assign ang_o   = acc_q[Run];
  assign tag_o   = tag_q[Run];
endmodule

// File: rtl/spherical_uv_mapping_core.sv
// Top level of the spherical UV mapping core: clamp, square root, two CORDICs, output stage.
// Depends on suvm_pkg and suvm_cordic_pipe.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+---------------------------
//  input   | in_valid_i | in_stall_o | x_i, y_i, z_i
//  output  | out_valid_o| out_stall_i| u_o, v_o, y_clamped_o
//
// One vertex can enter per cycle unless the pipeline is frozen. The path is one input register,
// COORD_WIDTH - 1 square-root stages, one CORDIC entry stage, CORDIC_STAGES (at most 32)
// rotation stages and one output register.
// The whole pipeline advances together; it freezes, bubbles included, only while
// the output register holds a result and the output is stalled.
// Reset clears only valid bits; the data registers are not reset.
module spherical_uv_mapping_core #(
  parameter int unsigned COORD_WIDTH   = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] x_i,
  input  logic signed [COORD_WIDTH-1:0] y_i,
  input  logic signed [COORD_WIDTH-1:0] z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [15:0]                   u_o,
  output logic [15:0]                   v_o,
  output logic                          y_clamped_o
);
  import suvm_pkg::*;

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned SqW   = 2 * CW;            // radicand width
  localparam int unsigned SqN   = CW - 1;            // result bits of isqrt
  localparam int unsigned Shift = 46 - CW;
  localparam logic signed [CW-1:0] One = CW'(1) <<< (CW - 2);

  logic en;
  logic out_vld_q;
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  // Clamp y and form 1 - y*y at full width.
  logic signed [CW-1:0]  yc;
  logic signed [SqW-1:0] yw;
  logic                  flag;
  logic [SqW-1:0]        rad;
  always_comb begin
    yc = y_i; flag = 1'b0;
    if (y_i > One) begin
      yc = One; flag = 1'b1;
    end else if (y_i < -One) begin
      yc = -One; flag = 1'b1;
    end
    yw  = SqW'(yc);
    rad = (SqW'(1) << (2 * (CW - 2))) - SqW'(yw * yw);
  end

  // Restoring square root, one result bit per stage, with the vertex alongside.
  logic                 sv_q [SqN+1];
  logic [SqW-1:0]       sn_q [SqN+1];
  logic [SqW-1:0]       sr_q [SqN+1];
  logic signed [CW-1:0] sx_q [SqN+1], sy_q [SqN+1], sz_q [SqN+1];
  logic                 sf_q [SqN+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q[0] <= 1'b0;
    else if (en) sv_q[0] <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sn_q[0] <= rad; sr_q[0] <= '0;
      sx_q[0] <= x_i; sy_q[0] <= yc; sz_q[0] <= z_i; sf_q[0] <= flag;
    end
  end

  for (genvar k = 0; k < SqN; k++) begin : g_sqrt
    localparam int unsigned BitPos = 2 * (SqN - 1 - k);
    logic [SqW-1:0] bt, tr;
    assign bt = SqW'(1) << BitPos;
    assign tr = sr_q[k] + bt;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[k+1] <= 1'b0;
      else if (en) sv_q[k+1] <= sv_q[k];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (sn_q[k] >= tr) begin
          sn_q[k+1] <= sn_q[k] - tr;
          sr_q[k+1] <= (sr_q[k] >> 1) + bt;
        end else begin
          sn_q[k+1] <= sn_q[k];
          sr_q[k+1] <= sr_q[k] >> 1;
        end
        sx_q[k+1] <= sx_q[k]; sy_q[k+1] <= sy_q[k];
        sz_q[k+1] <= sz_q[k]; sf_q[k+1] <= sf_q[k];
      end
    end
  end

  // Two CORDICs in lockstep: longitude and latitude.
  localparam int unsigned InW = CW + 1;
  logic                   lon_vld, lat_vld;
  logic signed [AngW-1:0] lon, lat;
  logic                   lon_tag, lat_tag;

  suvm_cordic_pipe #(.InW(InW), .Stages(CORDIC_STAGES), .Shift(Shift), .TagW(1)) u_lon (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sv_q[SqN]),
    .a_i(InW'(sx_q[SqN])), .b_i(InW'(sz_q[SqN])), .tag_i(sf_q[SqN]),
    .valid_o(lon_vld), .ang_o(lon), .tag_o(lon_tag)
  );

  suvm_cordic_pipe #(.InW(InW), .Stages(CORDIC_STAGES), .Shift(Shift), .TagW(1)) u_lat (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sv_q[SqN]),
    .a_i(signed'({1'b0, sr_q[SqN][CW-1:0]})), .b_i(InW'(sy_q[SqN])), .tag_i(sf_q[SqN]),
    .valid_o(lat_vld), .ang_o(lat), .tag_o(lat_tag)
  );

  // Output register: offset, round and saturate.
  logic [15:0] u_q, v_q;
  logic        f_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= lon_vld & lat_vld;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q <= to_q16((AngW+2)'(HalfTurn) + (AngW+2)'(lon));
      v_q <= to_q16((AngW+2)'(HalfTurn) + ((AngW+2)'(lat) <<< 1));
      f_q <= lon_tag & lat_tag;
    end
  end

  assign out_valid_o = out_vld_q;
  assign u_o         = u_q;
  assign v_o         = v_q;
  assign y_clamped_o = f_q;
endmodule

// File: rtl/suvm_checker.sv
// Port-level checker for spherical_uv_mapping_core, bound to every instance.
// Uses only the top level's ports.
module suvm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] v_o,
  input logic        y_clamped_o
);
  // The core stalls its input only when a result is held back.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i)) else $error("stall without held result");

  // A held result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(v_o)))
    else $error("stalled result changed");

  // A clamped latitude lies at a pole.
  a_clamp_pole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && y_clamped_o) |-> (v_o == 16'd0 || v_o == 16'hFFFF))
    else $error("clamped latitude not at a pole");
endmodule

bind spherical_uv_mapping_core suvm_checker u_suvm_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .v_o, .y_clamped_o
);

// File: tb/sv/tb_top.sv
// Testbench for spherical_uv_mapping_core: random and directed vertices, checked
// against a fixed-point CORDIC predictor of u, v and the clamp flag.
// Depends on suvm_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CW = 16;
  localparam int unsigned STAGES = 16;
  localparam int unsigned WORK_SH = 46 - CW;
  localparam int unsigned PIPE_DEPTH = 1 + (CW - 1) + 1 + STAGES + 1;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic [15:0] u;
    logic [15:0] v;
    logic        clamped;
  } uv_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CW-1:0] x_i = '0, y_i = '0, z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [15:0] u_o, v_o;
  logic y_clamped_o;

  vertex_t pending_vertices[$];
  uv_t     expected_uv[$];
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  bit      hold_off = 1'b0;

  spherical_uv_mapping_core #(.COORD_WIDTH(CW), .CORDIC_STAGES(STAGES)) uut (.*);

  // Clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic longint atan_step(int i);
    longint t[32] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
      'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
      'h00000001, 'h00000000};
    return t[i];
  endfunction

  // Vectoring CORDIC: atan2(b, a) in units of 2^-32 turn.
  function automatic longint vector_angle(longint a, longint b);
    longint acc, da, db;
    acc = 0;
    if (b == 0) return (a < 0) ? (longint'(1) << 31) : 0;
    if (a == 0) return (b > 0) ? (longint'(1) << 30) : -(longint'(1) << 30);
    if (a < 0) begin
      acc = (b > 0) ? (longint'(1) << 31) : -(longint'(1) << 31);
      a = -a;
      b = -b;
    end
    a = a <<< WORK_SH;
    b = b <<< WORK_SH;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a += da; b -= db; acc += atan_step(i);
      end else begin
        a -= da; b += db; acc -= atan_step(i);
      end
    end
    return acc;
  endfunction

  // Square root rounded down.
  function automatic longint floor_sqrt(longint n);
    longint r;
    r = 0;
    for (longint b = longint'(1) << 30; b != 0; b = b >> 1)
      if ((r + b) * (r + b) <= n) r += b;
    return r;
  endfunction

  function automatic logic [15:0] turns_to_q16(longint a);
    longint r;
    if (a < 0) return 16'd0;
    r = (a + 'h8000) >>> 16;
    return (r > 65535) ? 16'hFFFF : r[15:0];
  endfunction

  // Expected texture coordinates of one vertex.
  function automatic uv_t map_vertex(vertex_t vx);
    uv_t r;
    longint one, yy, c, lon, lat;
    one = longint'(1) << (CW - 2);
    yy = vx.y;
    r.clamped = 1'b0;
    if (yy > one) begin
      yy = one; r.clamped = 1'b1;
    end else if (yy < -one) begin
      yy = -one; r.clamped = 1'b1;
    end
    c = floor_sqrt(one * one - yy * yy);
    lon = vector_angle(longint'(vx.x), longint'(vx.z));
    lat = vector_angle(c, yy);
    r.u = turns_to_q16((longint'(1) << 31) + lon);
    r.v = turns_to_q16((longint'(1) << 31) + 2 * lat);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Appends one vertex to the pending requests.
  task automatic queue_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                              input logic signed [CW-1:0] z);
    vertex_t vx;
    vx.x = x;
    vx.y = y;
    vx.z = z;
    pending_vertices.insert(pending_vertices.size(), vx);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? 16'sh4000 : -16'sh4000;
      1: return 16'(int'($urandom_range(0, 6)) - 3);
      2: return 16'($urandom_range(16'hC000, 16'hFFFF) & 16'hFFFF) ^
                (16'($urandom_range(0, 1)) << 15) & 16'h8000 | 16'h0;
      default: return 16'($urandom());
    endcase
  endfunction

  // Driver: bursts of requests with random gaps.
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (in_valid_i) expected_uv.insert(expected_uv.size(), map_vertex('{x_i, y_i, z_i}));
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_vertices.size() > 0) begin
          vertex_t vx;
          vx = pending_vertices.pop_front();
          in_valid_i <= 1'b1;
          x_i <= vx.x; y_i <= vx.y; z_i <= vx.z;
          if (burst_left <= 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off.
  int stall_run = 0;
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: out_stall_i <= 1'b1;
        1: out_stall_i <= 1'b0;
        default: begin
          out_stall_i <= 1'($urandom_range(0, 1));
          stall_run <= $urandom_range(0, 20);
        end
      endcase
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_uv.size() == 0) begin
        report_mismatch("unexpected result u", u_o, -1);
      end else begin
        uv_t e;
        e = expected_uv.pop_front();
        if (u_o !== e.u) report_mismatch("u", u_o, e.u);
        if (v_o !== e.v) report_mismatch("v", v_o, e.v);
        if (y_clamped_o !== e.clamped) report_mismatch("y_clamped", y_clamped_o, e.clamped);
      end
    end
  end

  // Watchdog on cycles with no accepted request at either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    logic signed [CW-1:0] ext[6];
    ext = '{16'sh7FFF, -16'sh8000, 16'sh4000, -16'sh4000, 16'sh0000, 16'sh0001};
    // Zero vector, axis directions, poles, out-of-range latitude, extremes.
    foreach (ext[i]) queue_vertex(ext[i], ext[i], 16'sh0000);
    foreach (ext[i]) queue_vertex(16'sh0000, ext[5 - i], ext[i]);
    queue_vertex(-16'sh4000, 16'sh0000, 16'sh0000);
    queue_vertex(-16'sh8000, 16'sh4001, 16'sh0001);
    queue_vertex(-16'sh8000, -16'sh4001, -16'sh0001);
    queue_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    queue_vertex(-16'sh8000, -16'sh8000, -16'sh8000);
    for (int i = 0; i < 800; i++)
      queue_vertex(rand_coord(), rand_coord(), rand_coord());
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Long receiver hold-off while the sender keeps offering.
    repeat (60) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off <= 1'b0;
    wait (pending_vertices.size() == 0 && !in_valid_i && expected_uv.size() == 0);
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_uv.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
